FILE: design/utf8_char_segmenter_defines.svh
// Assertion macros used by the result-channel checker of the UTF-8 segmenter.
// Needs nothing else; include it by its bare file name.
`ifndef UTF8_CHAR_SEGMENTER_DEFINES_SVH
`define UTF8_CHAR_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U8CS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define U8CS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/utf8cs_pkg.sv
// Shared types and constants of the UTF-8 character segmenter.
// Depends on nothing; used by the segmenting stage, the result bank and the top level.
package utf8cs_pkg;

   localparam int MAX_CHARS  = 4;   // most characters one input byte can release
   localparam int PEND_DEPTH = 3;   // bytes of an incomplete sequence held back

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] BAD_C0     = 8'hC0;
   localparam logic [7:0] BAD_C1     = 8'hC1;
   localparam logic [7:0] BAD_MIN    = 8'hF5;

   typedef struct packed {
      logic [31:0] packed_char;
      logic [2:0]  byte_count;
      logic        well_formed;
      logic        last_of_run;
      logic        string_done;
   } char_type;

   // Everything one input byte produces: released characters and leftovers.
   typedef struct packed {
      char_type [MAX_CHARS-1:0]  chars;
      logic [2:0]                num_chars;
      logic [PEND_DEPTH-1:0][7:0] pend_bytes;
      logic [1:0]                pend_count;
   } seg_out_type;

   // Load request from the segmenting stage into the result buffer.
   typedef struct packed {
      logic                     valid;
      logic [2:0]               count;
      char_type [MAX_CHARS-1:0] chars;
   } load_type;

endpackage

FILE: design/utf8cs_segment.sv
// Combinational segmentation of the pending bytes plus one new byte.
// Depends on utf8cs_pkg.
module utf8cs_segment (
   input  logic [utf8cs_pkg::PEND_DEPTH-1:0][7:0] pend_bytes,
   input  logic [1:0]                            pend_count,
   input  logic [7:0]                            byte_in,
   input  logic                                  end_of_string,
   output utf8cs_pkg::seg_out_type               seg_out
);
   import utf8cs_pkg::*;

   function automatic logic [2:0] seq_length(input logic [7:0] lead);
      logic [2:0] len;
      if ((lead & LEAD2_MASK) == LEAD2_CODE)      len = 3'd2;
      else if ((lead & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
      else if ((lead & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
      else                                        len = 3'd1;
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_CODE;
   endfunction

   function automatic logic is_bad(input logic [7:0] b);
      return b inside {BAD_C0, BAD_C1, [BAD_MIN:8'hFF]};
   endfunction

   function automatic seg_out_type segment(input logic [PEND_DEPTH-1:0][7:0] pend,
                                           input logic [1:0] cnt,
                                           input logic [7:0] b,
                                           input logic       eos);
      logic [3:0][7:0] bufr;
      logic [2:0]      n;
      logic [2:0]      need;
      logic [2:0]      avail;
      logic [2:0]      take;
      logic            broken;
      logic            stop;
      logic            wf;
      logic [31:0]     pk;
      logic [1:0]      last_idx;
      seg_out_type     r;
      r        = '0;
      bufr     = {8'h00, pend};
      bufr[cnt] = b;
      n        = {1'b0, cnt} + 3'd1;
      stop     = 1'b0;
      for (int s = 0; s < MAX_CHARS; s++) begin
         if (n != 3'd0 && !stop) begin
            need   = seq_length(bufr[0]);
            avail  = (n < need) ? n : need;
            broken = 1'b0;
            for (int i = 1; i < 4; i++) begin
               if (3'(i) < avail && !is_cont(bufr[i])) broken = 1'b1;
            end
            if (broken)            take = 3'd1;
            else if (avail < need) take = eos ? 3'd1 : 3'd0;
            else                   take = need;
            if (take == 3'd0) begin
               // Sequence still incomplete: hold the bytes for the next item.
               stop = 1'b1;
            end else begin
               case (take)
                  3'd1:    pk = {24'h0, bufr[0]};
                  3'd2:    pk = {16'h0, bufr[0], bufr[1]};
                  3'd3:    pk = {8'h0, bufr[0], bufr[1], bufr[2]};
                  default: pk = {bufr[0], bufr[1], bufr[2], bufr[3]};
               endcase
               if (take == 3'd1) begin
                  wf = ~bufr[0][7];
               end else begin
                  wf = 1'b1;
                  for (int i = 0; i < 4; i++) begin
                     if (3'(i) < take && is_bad(bufr[i])) wf = 1'b0;
                  end
               end
               r.chars[s]   = '{packed_char: pk, byte_count: take, well_formed: wf,
                                last_of_run: 1'b0, string_done: 1'b0};
               r.num_chars  = 3'(s + 1);
               case (take)
                  3'd1:    bufr = {8'h00, bufr[3:1]};
                  3'd2:    bufr = {16'h0000, bufr[3:2]};
                  3'd3:    bufr = {24'h000000, bufr[3]};
                  default: bufr = '0;
               endcase
               n = n - take;
            end
         end
      end
      r.pend_bytes = bufr[PEND_DEPTH-1:0];
      r.pend_count = n[1:0];
      if (r.num_chars != 3'd0) begin
         last_idx = 2'(r.num_chars - 3'd1);
         r.chars[last_idx].last_of_run = 1'b1;
         r.chars[last_idx].string_done = eos;
      end
      return r;
   endfunction

   always_comb begin
      seg_out = segment(pend_bytes, pend_count, byte_in, end_of_string);
   end

endmodule

FILE: design/utf8cs_result_buf.sv
// Result register bank: holds the characters of one input byte and hands
// them out one per handshake. Depends on utf8cs_pkg.
module utf8cs_result_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  utf8cs_pkg::load_type load,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output utf8cs_pkg::char_type head
);
   import utf8cs_pkg::*;

   char_type [MAX_CHARS-1:0] entries_ff, entries_in;
   logic [2:0]               count_ff, count_in;
   logic                     pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign head      = entries_ff[0];
   // A new set may land when the bank is empty or its last entry leaves now.
   assign can_load  = (count_ff == 3'd0) || (count_ff == 3'd1 && pop);

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      if (load.valid) begin
         entries_in = load.chars;
         count_in   = load.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_CHARS - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/utf8_char_segmenter.sv
// Top level of the UTF-8 character segmenter: input register, pending-byte
// state and result bank. Depends on utf8cs_pkg, utf8cs_segment, utf8cs_result_buf.
//
//  Channel  Direction  Handshake            Item contents
//  req_     in         req_valid/req_ready  byte_in, end_of_string
//  rsp_     out        rsp_valid/rsp_ready  packed_char, byte_count, well_formed,
//                                           last_of_run, string_done
//
// An accepted byte is held in the input register and segmented there; its
// characters land in the result bank once the bank has room, and the first one
// then shows on rsp_. With the output always ready the block takes one byte per
// cycle as long as each byte releases at most one character; a byte that
// releases several characters keeps the result bank busy until it has handed
// them out, and that bank sets the rate.
// A byte that only extends an incomplete sequence produces nothing and passes
// without waiting on the result bank.
// Synchronous active-high reset empties the input register, the result bank
// and the pending bytes.
module utf8_char_segmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_packed_char,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_well_formed,
   output logic        rsp_last_of_run,
   output logic        rsp_string_done
);
   import utf8cs_pkg::*;

   // Input register: one byte waiting to be segmented.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_end_ff, in_end_in;

   // Bytes of an incomplete sequence, oldest in slot zero.
   logic [PEND_DEPTH-1:0][7:0] pending_bytes_ff, pending_bytes_in;
   logic [1:0]                 pending_count_ff, pending_count_in;

   seg_out_type seg_out;
   load_type    load;
   char_type    head;
   logic        can_load;
   logic        advance;
   logic        take_req;

   utf8cs_segment u_segment (
      .pend_bytes    (pending_bytes_ff),
      .pend_count    (pending_count_ff),
      .byte_in       (in_byte_ff),
      .end_of_string (in_end_ff),
      .seg_out       (seg_out)
   );

   // The held byte moves on when it releases nothing, or the bank has room.
   assign advance   = in_valid_ff && ((seg_out.num_chars == 3'd0) || can_load);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   assign load.valid = advance && (seg_out.num_chars != 3'd0);
   assign load.count = seg_out.num_chars;
   assign load.chars = seg_out.chars;

   utf8cs_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_packed_char = head.packed_char;
   assign rsp_byte_count  = head.byte_count;
   assign rsp_well_formed = head.well_formed;
   assign rsp_last_of_run = head.last_of_run;
   assign rsp_string_done = head.string_done;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
         in_end_in   = req_end_of_string;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Pending state follows the segmenter only when the held byte is retired.
   always_comb begin
      pending_bytes_in = pending_bytes_ff;
      pending_count_in = pending_count_ff;
      if (advance) begin
         pending_bytes_in = seg_out.pend_bytes;
         pending_count_in = seg_out.pend_count;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      if (reset) begin
         in_valid_ff      <= 1'b0;
         pending_bytes_ff <= '0;
         pending_count_ff <= 2'd0;
      end else begin
         in_valid_ff      <= in_valid_in;
         pending_bytes_ff <= pending_bytes_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

FILE: design/utf8cs_checker.sv
// Port-level checks on the result channel of the UTF-8 segmenter, bound to
// the top level. Depends on utf8_char_segmenter_defines.svh.
`include "utf8_char_segmenter_defines.svh"

module utf8cs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_packed_char,
   input logic [2:0]  rsp_byte_count,
   input logic        rsp_well_formed,
   input logic        rsp_last_of_run,
   input logic        rsp_string_done
);

   // A character is one to four bytes long.
   `U8CS_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, (rsp_byte_count != 3'd0) && (rsp_byte_count <= 3'd4), "byte_count out of range")

   // A lone byte is zero-extended and well formed only when it is ASCII.
   `U8CS_ASSERT_NOW(a_single_byte, clock, reset, rsp_valid && (rsp_byte_count == 3'd1), (rsp_packed_char[31:8] == 24'h0) && (rsp_well_formed == !rsp_packed_char[7]), "bad single-byte character")

   // The end of a string always closes the run of its last input byte.
   `U8CS_ASSERT_NOW(a_done_is_last, clock, reset, rsp_valid && rsp_string_done, rsp_last_of_run, "string_done without last_of_run")

   // A stalled character stays on the port unchanged.
   `U8CS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_packed_char) && $stable(rsp_byte_count), "result changed while stalled")

endmodule

bind utf8_char_segmenter utf8cs_checker u_checker (.*);

FILE: dv/utf8_char_segmenter_test.sv
// Self-checking testbench for utf8_char_segmenter: directed string table, then random strings.
// Depends on utf8cs_pkg and the utf8_char_segmenter RTL; it reads no files and needs no options.
module utf8_char_segmenter_test;
   import utf8cs_pkg::*;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_BYTES  = 306;
   localparam int IDLE_PERCENT  = 27;
   localparam int HOLD_CYCLES   = 80;    // long receiver hold-off that backs up the block
   localparam int QUIET_LIMIT   = 1000;  // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 10;    // settling time after the last expected result
   localparam int REPORT_LIMIT  = 10;

   // One row of stimulus. Where typed is set, want holds the single character that the
   // row must produce, and the predictor only keeps its state in step.
   typedef struct packed {
      logic [7:0] code;
      logic       eos;
      logic       typed;
      char_type   want;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_packed_char;
   logic [2:0]  rsp_byte_count;
   logic        rsp_well_formed;
   logic        rsp_last_of_run;
   logic        rsp_string_done;

   // Predictor state: bytes of an incomplete sequence, oldest first.
   logic [7:0]  carry_bytes [0:PEND_DEPTH-1] = '{8'h00, 8'h00, 8'h00};
   int unsigned carry_count = 0;
   char_type    chars_due [$];

   // Information about the item currently offered, read by the monitor on acceptance.
   logic        offer_typed = 1'b0;
   char_type    offer_want = '0;

   int unsigned fault_count = 0;
   int unsigned bytes_taken = 0;
   int unsigned quiet_cycles = 0;
   logic        took_any;
   char_type    due;
   logic        steady = 1'b0;      // when set, neither side inserts idle cycles
   logic        drain_held = 1'b0;

   utf8_char_segmenter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packed_char   (rsp_packed_char),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_well_formed   (rsp_well_formed),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_string_done   (rsp_string_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic step_type free_row(input logic [7:0] code, input logic eos);
      step_type s;
      s = '0;
      s.code = code;
      s.eos = eos;
      return s;
   endfunction

   function automatic step_type typed_row(input logic [7:0] code, input logic eos,
                                          input logic [31:0] word, input logic [2:0] count,
                                          input logic wf, input logic done);
      step_type s;
      s.code = code;
      s.eos = eos;
      s.typed = 1'b1;
      s.want.packed_char = word;
      s.want.byte_count = count;
      s.want.well_formed = wf;
      s.want.last_of_run = 1'b1;
      s.want.string_done = done;
      return s;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   // Appends one byte to the held bytes and cuts off every character that is now
   // complete. A sequence whose lead is followed by a non-continuation gives up its
   // lead as a lone byte, and the rest is looked at again as a fresh start. With the
   // final byte of a string nothing may stay held, so incomplete leads also go out
   // alone. When record is clear the characters are worked out but not queued.
   task automatic split_byte(input logic [7:0] code, input logic eos, input logic record);
      logic [7:0]  run [0:3];
      int unsigned n, need, avail, take, i;
      logic        broken, stalled;
      char_type    ch;
      char_type    made [$];
      for (i = 0; i < PEND_DEPTH; i++) begin
         run[i] = carry_bytes[i];
      end
      run[3] = 8'h00;
      n = carry_count;
      run[n] = code;
      n++;
      stalled = 1'b0;
      while (n > 0 && !stalled && made.size() < MAX_CHARS) begin
         if ((run[0] & LEAD2_MASK) == LEAD2_CODE) need = 2;
         else if ((run[0] & LEAD3_MASK) == LEAD3_CODE) need = 3;
         else if ((run[0] & LEAD4_MASK) == LEAD4_CODE) need = 4;
         else need = 1;
         avail = (n < need) ? n : need;
         broken = 1'b0;
         for (i = 1; i < avail; i++) begin
            if ((run[i] & CONT_MASK) != CONT_CODE) broken = 1'b1;
         end
         take = need;
         if (broken) begin
            take = 1;
         end else if (avail < need) begin
            if (eos) take = 1;
            else stalled = 1'b1;
         end
         if (!stalled) begin
            ch = '0;
            for (i = 0; i < take; i++) begin
               ch.packed_char = {ch.packed_char[23:0], run[i]};
            end
            ch.byte_count = 3'(take);
            if (take == 1) begin
               // A lone byte is only well formed when it is plain ASCII.
               ch.well_formed = (run[0] < CONT_CODE);
            end else begin
               ch.well_formed = 1'b1;
               for (i = 0; i < take; i++) begin
                  if (run[i] == BAD_C0 || run[i] == BAD_C1 || run[i] >= BAD_MIN)
                     ch.well_formed = 1'b0;
               end
            end
            made.push_back(ch);
            for (i = 0; i + take < n; i++) begin
               run[i] = run[i + take];
            end
            n = n - take;
         end
      end
      for (i = 0; i < PEND_DEPTH; i++) begin
         carry_bytes[i] = (i < n) ? run[i] : 8'h00;
      end
      carry_count = n;
      if (made.size() > 0) begin
         made[made.size() - 1].last_of_run = 1'b1;
         made[made.size() - 1].string_done = eos;
      end
      if (record) begin
         foreach (made[j]) chars_due.push_back(made[j]);
      end
   endtask

   // Offers one item starting at a falling edge and returns at the falling edge after
   // it was taken. Valid is only lowered when an idle gap follows, so a back-to-back
   // item never sees valid dropped and raised in the same step.
   task automatic offer(input step_type s);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      offer_typed = s.typed;
      offer_want = s.want;
      req_valid <= 1'b1;
      req_byte_in <= s.code;
      req_end_of_string <= s.eos;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Receiver. Once enough bytes have gone in it refuses results for a long stretch,
   // so the result bank fills and the block has to stall its input.
   initial begin
      forever begin
         @(negedge clock);
         if (!drain_held && bytes_taken >= 60) begin
            drain_held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: checks every character that leaves the block against the oldest one
   // expected, and predicts the characters of every byte that goes in.
   always @(posedge clock) begin
      if (!reset) begin
         took_any = 1'b0;
         if (rsp_valid && rsp_ready) begin
            took_any = 1'b1;
            if (chars_due.size() == 0) begin
               note_fault($sformatf("unexpected character %h (%0d bytes)",
                                    rsp_packed_char, rsp_byte_count));
            end else begin
               due = chars_due.pop_front();
               if (rsp_packed_char !== due.packed_char)
                  note_fault($sformatf("packed_char got %h want %h",
                                       rsp_packed_char, due.packed_char));
               if (rsp_byte_count !== due.byte_count)
                  note_fault($sformatf("byte_count got %0d want %0d (char %h)",
                                       rsp_byte_count, due.byte_count, due.packed_char));
               if (rsp_well_formed !== due.well_formed)
                  note_fault($sformatf("well_formed got %b want %b (char %h)",
                                       rsp_well_formed, due.well_formed, due.packed_char));
               if (rsp_last_of_run !== due.last_of_run)
                  note_fault($sformatf("last_of_run got %b want %b (char %h)",
                                       rsp_last_of_run, due.last_of_run, due.packed_char));
               if (rsp_string_done !== due.string_done)
                  note_fault($sformatf("string_done got %b want %b (char %h)",
                                       rsp_string_done, due.string_done, due.packed_char));
            end
         end
         if (req_valid && req_ready) begin
            took_any = 1'b1;
            bytes_taken++;
            if (offer_typed) begin
               split_byte(req_byte_in, req_end_of_string, 1'b0);
               chars_due.push_back(offer_want);
            end else begin
               split_byte(req_byte_in, req_end_of_string, 1'b1);
            end
         end
         quiet_cycles = took_any ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("utf8_char_segmenter verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      step_type    directed_steps [0:DIRECTED_ROWS-1];
      logic [7:0]  text [$];
      logic [7:0]  wild;
      int unsigned random_sent, chars, pick, lead_len, keep, c, k;
      logic        paused;

      // Single bytes at the extremes come first, so their results are typed in.
      // The rest covers each sequence length, some bad bytes, a broken sequence, a
      // string cut off inside a character, and one byte that releases four characters.
      directed_steps = '{
         typed_row(8'h41, 1'b0, 32'h0000_0041, 3'd1, 1'b1, 1'b0),
         typed_row(8'h00, 1'b0, 32'h0000_0000, 3'd1, 1'b1, 1'b0),
         typed_row(8'hFF, 1'b0, 32'h0000_00FF, 3'd1, 1'b0, 1'b0),
         typed_row(8'h80, 1'b1, 32'h0000_0080, 3'd1, 1'b0, 1'b1),
         free_row(8'hE2, 1'b0), free_row(8'h82, 1'b0), free_row(8'hAC, 1'b0),
         free_row(8'hF4, 1'b0), free_row(8'h8F, 1'b0), free_row(8'hBF, 1'b0),
         free_row(8'hBF, 1'b1),
         free_row(8'hC0, 1'b0), free_row(8'h80, 1'b0),
         free_row(8'hF5, 1'b0), free_row(8'h80, 1'b0), free_row(8'h80, 1'b0),
         free_row(8'h80, 1'b0),
         free_row(8'hF0, 1'b0), free_row(8'h9F, 1'b0), free_row(8'h98, 1'b1),
         free_row(8'hF0, 1'b0), free_row(8'h80, 1'b0), free_row(8'h80, 1'b0),
         free_row(8'h41, 1'b1)
      };

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         offer(directed_steps[r]);
      end

      // Random strings, mostly made of well-formed characters with random payload
      // bits. Some continuations are dropped to break sequences, and some bytes are
      // pure noise, such as stray continuations or bytes that can never lead.
      random_sent = 0;
      paused = 1'b0;
      while (random_sent < RANDOM_BYTES) begin
         steady = (random_sent >= 120 && random_sent < 200);
         text.delete();
         chars = $urandom_range(10, 1);
         for (c = 0; c < chars; c++) begin
            pick = $urandom_range(99);
            wild = 8'($urandom);
            if (pick < 35) begin
               lead_len = 1;
               text.push_back({1'b0, wild[6:0]});
            end else if (pick < 55) begin
               lead_len = 2;
               text.push_back({3'b110, wild[4:0]});
            end else if (pick < 72) begin
               lead_len = 3;
               text.push_back({4'b1110, wild[3:0]});
            end else if (pick < 87) begin
               lead_len = 4;
               text.push_back({5'b11110, wild[2:0]});
            end else begin
               lead_len = 1;
               text.push_back(wild);
            end
            keep = lead_len - 1;
            if (lead_len > 1 && $urandom_range(9) == 0) keep = $urandom_range(lead_len - 2);
            for (k = 0; k < keep; k++) begin
               wild = 8'($urandom);
               text.push_back({2'b10, wild[5:0]});
            end
         end
         foreach (text[j]) begin
            offer(free_row(text[j], j == text.size() - 1));
         end
         random_sent += text.size();

         // Once, the sender stops and waits until the block has handed out everything.
         if (!paused && random_sent >= 230) begin
            paused = 1'b1;
            if (chars_due.size() != 0) begin
               req_valid <= 1'b0;
               while (chars_due.size() != 0) @(negedge clock);
            end
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (chars_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (chars_due.size() != 0)
         note_fault($sformatf("%0d characters never came out", chars_due.size()));

      if (fault_count == 0) begin
         $display("utf8_char_segmenter verification clean");
      end else begin
         $display("utf8_char_segmenter verification failed");
      end
      $finish;
   end

endmodule
